// File: rtl/spr_pkg.sv
// Shared types, constants and a helper function of the spec-constant rewriter.
package spr_pkg;

  localparam int WORD_W          = 32;
  localparam int HALF_W          = 16;
  localparam int SPEC_VAL_W      = 33;
  localparam int KIND_BIT        = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int COUNT_W         = 3;
  localparam int SLOT_W          = 3;
  localparam int HDR_W           = 3;
  localparam int HDR_WORDS       = 5;
  localparam int MAP_ENTRIES_DEF = 16;
  localparam int SPEC_SLOTS_DEF  = 6;

  // Opcodes and decoration codes of interest.
  localparam logic [HALF_W-1:0] OP_DECORATE = 16'd71;
  localparam logic [HALF_W-1:0] OP_SC_TRUE  = 16'd48;
  localparam logic [HALF_W-1:0] OP_SC_FALSE = 16'd49;
  localparam logic [HALF_W-1:0] OP_SC       = 16'd50;
  localparam logic [HALF_W-1:0] OP_C_TRUE   = 16'd41;
  localparam logic [HALF_W-1:0] OP_C_FALSE  = 16'd42;
  localparam logic [HALF_W-1:0] OP_C        = 16'd43;
  localparam logic [WORD_W-1:0] DECO_SPEC_ID = 32'd1;

  // Word counts of the rewritten constant instructions.
  localparam logic [HALF_W-1:0] LEN_BOOL = 16'd3;
  localparam logic [HALF_W-1:0] LEN_LIT  = 16'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_VALUE0 = 3'd1;

  // Instruction class tracked by the front end.
  typedef enum logic [1:0] {
    CLS_COPY,
    CLS_SPEC,
    CLS_DECO,
    CLS_DROP
  } cls_t;

  // What the tail does with a word when it leaves the cell chain.
  typedef enum logic [3:0] {
    ACT_COPY,
    ACT_HOLD0,
    ACT_HOLD1,
    ACT_FLUSH0,
    ACT_FLUSH1,
    ACT_SC2,
    ACT_DEC2,
    ACT_SC3,
    ACT_DROP
  } act_t;

  // Table request carried through the cell chain.
  typedef enum logic [1:0] {
    REQ_NONE,
    REQ_LOOKUP,
    REQ_RECORD
  } req_t;

  // One word in flight through the cell chain.
  typedef struct packed {
    logic              vld;
    logic              fin;
    act_t              act;
    req_t              req;
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] key;
  } tok_t;

  // First word of the constant instruction that replaces a spec constant.
  function automatic logic [WORD_W-1:0] rewrite_first(input logic [SPEC_VAL_W-1:0] v);
    logic [WORD_W-1:0] res;
    if (v[KIND_BIT]) begin
      res = {LEN_BOOL, (v[0] ? OP_C_TRUE : OP_C_FALSE)};
    end else begin
      res = {LEN_LIT, OP_C};
    end
    return res;
  endfunction

endpackage

// File: rtl/spr_if.sv
// Valid/ready stream interfaces for the module word input and the result output.
interface spr_in_if;
  import spr_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] module_word;
  logic              final_word;

  modport source (output valid, output module_word, output final_word, input ready);
  modport sink (input valid, input module_word, input final_word, output ready);
endinterface

interface spr_out_if;
  import spr_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word;
  logic              word_valid;
  logic              last_of_run;
  logic              module_end;
  logic              map_overflow;

  modport source (output valid, output out_word, output word_valid, output last_of_run,
                  output module_end, output map_overflow, input ready);
  modport sink (input valid, input out_word, input word_valid, input last_of_run,
                input module_end, input map_overflow, output ready);
endinterface

// File: rtl/spr_front.sv
// Front end: tracks header, instruction position and class, and tags each word.
module spr_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld,
  input  logic                   acc,
  input  logic [spr_pkg::WORD_W-1:0] word,
  input  logic                   fin,
  output spr_pkg::tok_t          tok
);
  import spr_pkg::*;

  logic [HDR_W-1:0]  hdr_left_r, hdr_left_nxt;
  logic [HALF_W-1:0] pos_r, pos_nxt;
  logic [HALF_W-1:0] len_r, len_nxt;
  cls_t              cls_r, cls_nxt;
  logic [WORD_W-1:0] held1_r, held1_nxt;

  logic              at_start;
  logic [HALF_W-1:0] len_word;
  logic [HALF_W-1:0] len_cur;
  cls_t              cls_new;
  cls_t              cls_cur;
  cls_t              cls_mid;
  logic              ends;

  // Class of an instruction from its opcode.
  always_comb begin
    case (word[HALF_W-1:0])
      OP_SC, OP_SC_TRUE, OP_SC_FALSE: cls_new = CLS_SPEC;
      OP_DECORATE:                    cls_new = CLS_DECO;
      default:                        cls_new = CLS_COPY;
    endcase
  end

  // Decode the current word and choose its action.
  always_comb begin
    at_start = (pos_r == '0);
    len_word = word[WORD_W-1:HALF_W];
    len_cur  = at_start ? ((len_word == '0) ? HALF_W'(1) : len_word) : len_r;
    cls_cur  = at_start ? cls_new : cls_r;
    ends     = ({1'b0, pos_r} + (HALF_W+1)'(1)) >= {1'b0, len_cur};
    cls_mid  = cls_cur;

    tok      = '0;
    tok.vld  = vld;
    tok.fin  = fin;
    tok.word = word;
    tok.key  = word;
    tok.act  = ACT_COPY;
    tok.req  = REQ_NONE;

    if (hdr_left_r == '0) begin
      case (cls_cur)
        CLS_SPEC, CLS_DECO: begin
          if (pos_r == HALF_W'(0)) begin
            tok.act = (ends || fin) ? ACT_FLUSH0 : ACT_HOLD0;
          end else if (pos_r == HALF_W'(1)) begin
            tok.act = (ends || fin) ? ACT_FLUSH1 : ACT_HOLD1;
          end else if (pos_r == HALF_W'(2)) begin
            if (cls_cur == CLS_SPEC) begin
              tok.act = ACT_SC2;
              tok.req = REQ_LOOKUP;
            end else if (word == DECO_SPEC_ID) begin
              tok.act = ACT_DROP;
              cls_mid = CLS_DROP;
            end else begin
              tok.act = ACT_DEC2;
              cls_mid = CLS_COPY;
            end
          end else if (pos_r == HALF_W'(3)) begin
            tok.act = ACT_SC3;
          end
        end
        CLS_DROP: begin
          tok.act = ACT_DROP;
          if (pos_r == HALF_W'(3)) begin
            tok.req = REQ_RECORD;
            tok.key = held1_r;
          end
        end
        default: begin
          tok.act = ACT_COPY;
        end
      endcase
    end
  end

  // Position tracking; a final word starts a new module.
  always_comb begin
    hdr_left_nxt = hdr_left_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    cls_nxt      = cls_r;
    held1_nxt    = held1_r;
    if (acc) begin
      if (fin) begin
        hdr_left_nxt = HDR_W'(HDR_WORDS);
        pos_nxt      = '0;
        len_nxt      = '0;
        cls_nxt      = CLS_COPY;
      end else if (hdr_left_r != '0) begin
        hdr_left_nxt = hdr_left_r - HDR_W'(1);
      end else begin
        len_nxt = len_cur;
        if (pos_r == HALF_W'(1)) begin
          held1_nxt = word;
        end
        if (ends) begin
          pos_nxt = '0;
          cls_nxt = CLS_COPY;
        end else begin
          pos_nxt = pos_r + HALF_W'(1);
          cls_nxt = cls_mid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_left_r <= HDR_W'(HDR_WORDS);
      pos_r      <= '0;
      len_r      <= '0;
      cls_r      <= CLS_COPY;
    end else begin
      hdr_left_r <= hdr_left_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      cls_r      <= cls_nxt;
    end
  end

  // The decorate target id needs no reset.
  always_ff @(posedge clk) begin
    held1_r <= held1_nxt;
  end

endmodule

// File: rtl/spr_cell.sv
// One table cell: holds a result id to spec id pair and serves passing requests.
module spr_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [spr_pkg::COUNT_W-1:0] active,
  input  spr_pkg::tok_t               tok_i,
  output spr_pkg::tok_t               tok_o
);
  import spr_pkg::*;

  logic              ent_vld_r, ent_vld_nxt;
  logic [WORD_W-1:0] ent_id_r;
  logic [SLOT_W-1:0] ent_lo_r;
  logic              ent_big_r;
  tok_t              tok_r, tok_nxt;

  logic pend;
  logic id_eq;
  logic resolve;
  logic wr;

  // Resolve a pending request here: matching entry, or first free entry.
  always_comb begin
    pend    = tok_i.vld && (tok_i.req != REQ_NONE) && !tok_i.done;
    id_eq   = ent_vld_r && (ent_id_r == tok_i.key);
    resolve = pend && (id_eq || !ent_vld_r);
    wr      = resolve && (tok_i.req == REQ_RECORD);

    tok_nxt = tok_i;
    if (resolve) begin
      tok_nxt.done = 1'b1;
      if ((tok_i.req == REQ_LOOKUP) && id_eq) begin
        tok_nxt.hit  = !ent_big_r && (ent_lo_r < active);
        tok_nxt.slot = ent_lo_r;
      end
    end

    // A final word empties the table behind it.
    ent_vld_nxt = ent_vld_r;
    if (adv) begin
      if (wr) begin
        ent_vld_nxt = 1'b1;
      end
      if (tok_i.vld && tok_i.fin) begin
        ent_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      tok_r     <= '0;
    end else begin
      ent_vld_r <= ent_vld_nxt;
      if (adv) begin
        tok_r <= tok_nxt;
      end
    end
  end

  // Entry contents; the spec id is kept as its low bits and a too-large flag.
  always_ff @(posedge clk) begin
    if (adv && wr) begin
      ent_id_r  <= tok_i.key;
      ent_lo_r  <= tok_i.word[SLOT_W-1:0];
      ent_big_r <= |tok_i.word[WORD_W-1:SLOT_W];
    end
  end

  assign tok_o = tok_r;

endmodule

// File: rtl/spr_tail.sv
// Tail: builds the result transactions of each word and sends them one per cycle while the output is ready.
module spr_tail #(
  parameter int SPEC_SLOTS = spr_pkg::SPEC_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spr_pkg::tok_t                  tok_i,
  input  logic [spr_pkg::SPEC_VAL_W-1:0] spec_val [SPEC_SLOTS],
  output logic                           leave,
  spr_out_if.source                      out_ch
);
  import spr_pkg::*;

  logic [WORD_W-1:0] held0_r, held0_nxt;
  logic [WORD_W-1:0] held1_r, held1_nxt;
  logic              match_r, match_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              ovf_r, ovf_nxt;

  logic [WORD_W-1:0] ob_word_r [3];
  logic [1:0]        ob_cnt_r, ob_cnt_nxt;
  logic [1:0]        ob_idx_r, ob_idx_nxt;
  logic              ob_wv_r;
  logic              ob_fin_r;
  logic              ob_ovf_r;

  logic [SPEC_VAL_W-1:0] val_new;
  logic [SPEC_VAL_W-1:0] val_held;
  logic                  lk_hit;
  logic                  ovf_now;
  logic [WORD_W-1:0]     res_w [3];
  logic [1:0]            res_n;
  logic                  res_wv;
  logic                  take;
  logic                  ob_last;
  logic                  buf_free;
  logic                  load;
  logic                  step;

  // Specialization values for the new lookup and for the held match.
  always_comb begin
    val_new  = '0;
    val_held = '0;
    for (int k = 0; k < SPEC_SLOTS; k++) begin
      if (tok_i.slot == SLOT_W'(k)) begin
        val_new = spec_val[k];
      end
      if (slot_r == SLOT_W'(k)) begin
        val_held = spec_val[k];
      end
    end
  end

  // Result words of the word at the end of the chain.
  always_comb begin
    lk_hit  = (tok_i.req == REQ_LOOKUP) && tok_i.hit;
    ovf_now = ovf_r || ((tok_i.req == REQ_RECORD) && !tok_i.done);
    res_w[0] = tok_i.word;
    res_w[1] = tok_i.word;
    res_w[2] = tok_i.word;
    res_n    = 2'd0;
    res_wv   = 1'b1;
    case (tok_i.act)
      ACT_COPY, ACT_FLUSH0: begin
        res_n = 2'd1;
      end
      ACT_FLUSH1: begin
        res_n    = 2'd2;
        res_w[0] = held0_r;
      end
      ACT_SC2: begin
        res_n    = 2'd3;
        res_w[0] = lk_hit ? rewrite_first(val_new) : held0_r;
        res_w[1] = held1_r;
      end
      ACT_DEC2: begin
        res_n    = 2'd3;
        res_w[0] = held0_r;
        res_w[1] = held1_r;
      end
      ACT_SC3: begin
        res_n = 2'd1;
        if (match_r && !val_held[KIND_BIT]) begin
          res_w[0] = val_held[WORD_W-1:0];
        end
      end
      default: begin
        res_n = 2'd0;
      end
    endcase
    // A final word with nothing to send still reports the module end.
    if (tok_i.fin && (res_n == 2'd0)) begin
      res_n    = 2'd1;
      res_wv   = 1'b0;
      res_w[0] = '0;
    end
  end

  // Output buffer handshake and chain advance.
  always_comb begin
    take     = out_ch.valid && out_ch.ready;
    ob_last  = (ob_idx_r == (ob_cnt_r - 2'd1));
    buf_free = (ob_cnt_r == 2'd0) || (out_ch.ready && ob_last);
    leave    = !tok_i.vld || (res_n == 2'd0) || buf_free;
    load     = tok_i.vld && (res_n != 2'd0) && buf_free;
    step     = tok_i.vld && leave;

    ob_cnt_nxt = ob_cnt_r;
    ob_idx_nxt = ob_idx_r;
    if (take) begin
      if (ob_last) begin
        ob_cnt_nxt = 2'd0;
      end else begin
        ob_idx_nxt = ob_idx_r + 2'd1;
      end
    end
    if (load) begin
      ob_cnt_nxt = res_n;
      ob_idx_nxt = 2'd0;
    end
  end

  // Held words, match state and overflow flag.
  always_comb begin
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    match_nxt = match_r;
    slot_nxt  = slot_r;
    ovf_nxt   = ovf_r;
    if (step) begin
      if ((tok_i.act == ACT_HOLD0) || (tok_i.act == ACT_FLUSH0)) begin
        held0_nxt = tok_i.word;
      end
      if (tok_i.act == ACT_HOLD1) begin
        held1_nxt = tok_i.word;
      end
      if (tok_i.act == ACT_SC2) begin
        match_nxt = lk_hit;
        slot_nxt  = tok_i.slot;
      end
      ovf_nxt = ovf_now;
      if (tok_i.fin) begin
        match_nxt = 1'b0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r  <= 1'b0;
      ovf_r    <= 1'b0;
      ob_cnt_r <= 2'd0;
      ob_idx_r <= 2'd0;
    end else begin
      match_r  <= match_nxt;
      ovf_r    <= ovf_nxt;
      ob_cnt_r <= ob_cnt_nxt;
      ob_idx_r <= ob_idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
    slot_r  <= slot_nxt;
    if (load) begin
      ob_word_r[0] <= res_w[0];
      ob_word_r[1] <= res_w[1];
      ob_word_r[2] <= res_w[2];
      ob_wv_r      <= res_wv;
      ob_fin_r     <= tok_i.fin;
      ob_ovf_r     <= ovf_now;
    end
  end

  assign out_ch.valid        = (ob_cnt_r != 2'd0);
  assign out_ch.out_word     = ob_word_r[ob_idx_r];
  assign out_ch.word_valid   = ob_wv_r;
  assign out_ch.last_of_run  = ob_last;
  assign out_ch.module_end   = ob_fin_r && ob_last;
  assign out_ch.map_overflow = ob_ovf_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_cnt_r != 2'd0) |-> (ob_idx_r < ob_cnt_r))
    else $error("output buffer index past its result count");

  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    ((ob_cnt_r != 2'd0) && !ob_wv_r) |-> ((ob_cnt_r == 2'd1) && ob_fin_r))
    else $error("status-only result is not a lone module-end transaction");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_i.vld && !leave) |=> $stable(tok_i))
    else $error("cell chain moved while the tail was stalled");

endmodule

// File: rtl/spirv_spec_constant_rewriter_core.sv
// Top level of the streaming SPIR-V specialization-constant rewriter.
//
// Takes one module word per cycle while the chain advances and gives the
// rewritten stream in order. Each word passes a front-end decoder, then a chain
// of MAP_ENTRIES table cells (one cell per cycle while the chain advances, each
// cell holding one SpecId pair), then an output stage. The chain advances every
// cycle the output stage can take its last word, so words are accepted at one
// per cycle. The output port sends one result per cycle while the output is
// ready: dropped SpecId decorations produce nothing, while the first two words
// of a spec constant or decoration are held and sent together with the third
// as a run of three results. The table starts empty after reset and after
// every final word; no clearing pass is needed.
module spirv_spec_constant_rewriter_core #(
  parameter int MAP_ENTRIES = spr_pkg::MAP_ENTRIES_DEF,
  parameter int SPEC_SLOTS  = spr_pkg::SPEC_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  spr_in_if.sink                         in_ch,
  spr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [spr_pkg::SPEC_VAL_W-1:0] cfg_wdata
);
  import spr_pkg::*;

  logic [COUNT_W-1:0]    spec_count_r;
  logic [SPEC_VAL_W-1:0] spec_value_r [SPEC_SLOTS];
  logic [COUNT_W-1:0]    active;

  tok_t chain [MAP_ENTRIES+1];
  logic adv;
  logic acc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spec_count_r <= '0;
      for (int k = 0; k < SPEC_SLOTS; k++) begin
        spec_value_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_idx == CFG_SPEC_COUNT) begin
        spec_count_r <= cfg_wdata[COUNT_W-1:0];
      end
      for (int k = 0; k < SPEC_SLOTS; k++) begin
        if (cfg_idx == (CFG_SPEC_VALUE0 + CFG_IDX_W'(k))) begin
          spec_value_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // Number of usable specialization values.
  assign active = (spec_count_r < COUNT_W'(SPEC_SLOTS)) ? spec_count_r : COUNT_W'(SPEC_SLOTS);

  // Input transaction enters the first cell whenever the chain advances.
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && adv;

  spr_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .vld   (in_ch.valid),
    .acc   (acc),
    .word  (in_ch.module_word),
    .fin   (in_ch.final_word),
    .tok   (chain[0])
  );

  // Row of table cells.
  for (genvar g = 0; g < MAP_ENTRIES; g++) begin : g_cell
    spr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .active (active),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  spr_tail #(
    .SPEC_SLOTS (SPEC_SLOTS)
  ) u_tail (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_i    (chain[MAP_ENTRIES]),
    .spec_val (spec_value_r),
    .leave    (adv),
    .out_ch   (out_ch)
  );

endmodule
